// ===== rtl/core/mck_pkg.sv =====
// ----------------------------------------------------------------------------
// mck_pkg: Morse keyer shared definitions
// Character classes, code table and segment lengths used by the keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned UnitW     = 16;
  localparam int unsigned LenW      = 3;
  localparam int unsigned DurW      = 18;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned MaxElems  = 5;
  localparam int unsigned ElemCntW  = 3;

  localparam logic [UnitW-1:0] UnitTimeReset = 16'd100;

  localparam logic [LenW-1:0] UnitsDot       = 3'd1;
  localparam logic [LenW-1:0] UnitsDash      = 3'd3;
  localparam logic [LenW-1:0] UnitsElemGap   = 3'd1;
  localparam logic [LenW-1:0] UnitsLetterGap = 3'd3;
  localparam logic [LenW-1:0] UnitsWordExtra = 3'd4;

  // code table indices of the letters that spell out a full stop
  localparam logic [IdxW-1:0] StopLetters [4] = '{6'd28, 6'd29, 6'd24, 6'd25};

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CODE,
    KIND_SPACE,
    KIND_PERIOD
  } char_kind_e;

  // one letter's code: element count and pattern, bit i set = element i is a dash
  typedef struct packed {
    logic [ElemCntW-1:0] len;
    logic [MaxElems-1:0] pat;
  } code_t;

  typedef struct packed {
    logic load;
    logic emit_mark;
    logic emit_gap;
    logic emit_word;
  } mck_cmd_t;

  typedef struct packed {
    char_kind_e kind;
    logic       last_elem;
    logic       more_letters;
    logic       out_free;
  } mck_sts_t;

  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'h20;
    return r;
  endfunction

  function automatic char_kind_e char_kind(input logic [CharW-1:0] c);
    char_kind_e k;
    k = KIND_NONE;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a)) k = KIND_CODE;
    else if (c == 8'h20) k = KIND_SPACE;
    else if (c == 8'h2e) k = KIND_PERIOD;
    return k;
  endfunction

  // digits first, then a-z; only meaningful for KIND_CODE
  function automatic logic [IdxW-1:0] char_index(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    if (c <= 8'h39) r = c - 8'h30;
    else r = c - 8'h61 + 8'd10;
    return r[IdxW-1:0];
  endfunction

  function automatic code_t code_lookup(input logic [IdxW-1:0] idx);
    code_t r;
    unique case (idx)
      6'd0:  r = '{3'd5, 5'b11111};
      6'd1:  r = '{3'd5, 5'b11110};
      6'd2:  r = '{3'd5, 5'b11100};
      6'd3:  r = '{3'd5, 5'b11000};
      6'd4:  r = '{3'd5, 5'b10000};
      6'd5:  r = '{3'd5, 5'b00000};
      6'd6:  r = '{3'd5, 5'b00001};
      6'd7:  r = '{3'd5, 5'b00011};
      6'd8:  r = '{3'd5, 5'b00111};
      6'd9:  r = '{3'd5, 5'b01111};
      6'd10: r = '{3'd2, 5'b00010};
      6'd11: r = '{3'd4, 5'b00001};
      6'd12: r = '{3'd4, 5'b00101};
      6'd13: r = '{3'd3, 5'b00001};
      6'd14: r = '{3'd1, 5'b00000};
      6'd15: r = '{3'd4, 5'b00100};
      6'd16: r = '{3'd3, 5'b00011};
      6'd17: r = '{3'd4, 5'b00000};
      6'd18: r = '{3'd2, 5'b00000};
      6'd19: r = '{3'd4, 5'b01110};
      6'd20: r = '{3'd3, 5'b00101};
      6'd21: r = '{3'd4, 5'b00010};
      6'd22: r = '{3'd2, 5'b00011};
      6'd23: r = '{3'd2, 5'b00001};
      6'd24: r = '{3'd3, 5'b00111};
      6'd25: r = '{3'd4, 5'b00110};
      6'd26: r = '{3'd4, 5'b01011};
      6'd27: r = '{3'd3, 5'b00010};
      6'd28: r = '{3'd3, 5'b00000};
      6'd29: r = '{3'd1, 5'b00001};
      6'd30: r = '{3'd3, 5'b00100};
      6'd31: r = '{3'd4, 5'b01000};
      6'd32: r = '{3'd3, 5'b00110};
      6'd33: r = '{3'd4, 5'b01001};
      6'd34: r = '{3'd4, 5'b01101};
      6'd35: r = '{3'd4, 5'b00011};
      default: r = '{3'd1, 5'b00000};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/mck_ctrl.sv =====
// ----------------------------------------------------------------------------
// mck_ctrl: Morse keyer sequencer
// Walks a character through mark and gap segments, one per free output slot.
// ----------------------------------------------------------------------------
module mck_ctrl import mck_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mck_sts_t sts_i,
  output mck_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MARK = 2'd1;
  localparam logic [1:0] ST_GAP  = 2'd2;
  localparam logic [1:0] ST_WORD = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (sts_i.kind)
            KIND_CODE, KIND_PERIOD: state_d = ST_MARK;
            KIND_SPACE:             state_d = ST_WORD;
            default:                state_d = ST_IDLE;
          endcase
        end
      end
      ST_MARK: begin
        if (sts_i.out_free) begin
          cmd_o.emit_mark = 1'b1;
          state_d         = ST_GAP;
        end
      end
      ST_GAP: begin
        if (sts_i.out_free) begin
          cmd_o.emit_gap = 1'b1;
          if (!sts_i.last_elem || sts_i.more_letters) state_d = ST_MARK;
          else state_d = ST_IDLE;
        end
      end
      ST_WORD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_word = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // the word gap and the final letter gap both end the character
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_word || (cmd_o.emit_gap && sts_i.last_elem && !sts_i.more_letters))
    |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after final segment");

  a_mark_then_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_mark |=> state_q == ST_GAP)
    else $error("mark not followed by gap");
`endif

endmodule

// ===== rtl/core/mck_dp.sv =====
// ----------------------------------------------------------------------------
// mck_dp: Morse keyer datapath
// Holds the unit time, the current letter pattern and the segment register.
// ----------------------------------------------------------------------------
module mck_dp import mck_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  input  logic [CharW-1:0] char_code_i,
  input  mck_cmd_t         cmd_i,
  output mck_sts_t         sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             key_on_o,
  output logic [LenW-1:0]  length_units_o,
  output logic [DurW-1:0]  duration_ticks_o,
  output logic             last_segment_o
);

  logic [UnitW-1:0]    unit_q;
  logic [MaxElems-1:0] pat_q, pat_d;
  logic [ElemCntW-1:0] rem_q, rem_d;
  logic                period_q, period_d;
  logic [1:0]          stop_q, stop_d;
  logic                ovalid_q, ovalid_d;
  logic                key_q, last_q;
  logic [LenW-1:0]     len_q;
  logic [DurW-1:0]     dur_q;

  logic [CharW-1:0] ch;
  char_kind_e       kind;
  code_t            code;
  logic [IdxW-1:0]  idx;
  logic             emit;
  logic             seg_key, seg_last;
  logic [LenW-1:0]  seg_len;
  logic [1:0]       stop_nx;

  assign ch      = fold_case(char_code_i);
  assign kind    = char_kind(ch);
  assign stop_nx = stop_q + 2'd1;

  always_comb begin
    if (cmd_i.load) begin
      idx = (kind == KIND_PERIOD) ? StopLetters[0] : char_index(ch);
    end else begin
      idx = StopLetters[stop_nx];
    end
  end
  assign code = code_lookup(idx);

  assign sts_o.kind         = kind;
  assign sts_o.last_elem    = (rem_q == ElemCntW'(1));
  assign sts_o.more_letters = period_q && (stop_q != 2'd3);
  assign sts_o.out_free     = !ovalid_q || out_ready_i;

  assign emit = cmd_i.emit_mark || cmd_i.emit_gap || cmd_i.emit_word;

  always_comb begin
    seg_key  = 1'b0;
    seg_len  = UnitsWordExtra;
    seg_last = 1'b1;
    if (cmd_i.emit_mark) begin
      seg_key  = 1'b1;
      seg_len  = pat_q[0] ? UnitsDash : UnitsDot;
      seg_last = 1'b0;
    end else if (cmd_i.emit_gap) begin
      seg_len  = sts_o.last_elem ? UnitsLetterGap : UnitsElemGap;
      seg_last = sts_o.last_elem && !sts_o.more_letters;
    end
  end

  always_comb begin
    pat_d    = pat_q;
    rem_d    = rem_q;
    period_d = period_q;
    stop_d   = stop_q;
    if (cmd_i.load) begin
      pat_d    = code.pat;
      rem_d    = code.len;
      period_d = (kind == KIND_PERIOD);
      stop_d   = 2'd0;
    end else if (cmd_i.emit_gap) begin
      if (!sts_o.last_elem) begin
        pat_d = pat_q >> 1;
        rem_d = rem_q - ElemCntW'(1);
      end else if (sts_o.more_letters) begin
        // next letter of the full stop spelling
        pat_d  = code.pat;
        rem_d  = code.len;
        stop_d = stop_nx;
      end
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (emit) ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q   <= UnitTimeReset;
      ovalid_q <= 1'b0;
      period_q <= 1'b0;
      stop_q   <= 2'd0;
      rem_q    <= '0;
    end else begin
      if (cfg_we_i) unit_q <= cfg_wdata_i;
      ovalid_q <= ovalid_d;
      period_q <= period_d;
      stop_q   <= stop_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    if (emit) begin
      key_q  <= seg_key;
      len_q  <= seg_len;
      last_q <= seg_last;
      dur_q  <= DurW'(DurW'(seg_len) * DurW'(unit_q));
    end
  end

  assign out_valid_o      = ovalid_q;
  assign key_on_o         = key_q;
  assign length_units_o   = len_q;
  assign duration_ticks_o = dur_q;
  assign last_segment_o   = last_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!ovalid_q || out_ready_i))
    else $error("segment register overwritten before transfer");

  a_mark_has_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_mark || cmd_i.emit_gap) |-> rem_q != '0)
    else $error("segment emitted with no element left");
`endif

endmodule

// ===== rtl/core/morse_code_keyer_top.sv =====
// ----------------------------------------------------------------------------
// morse_code_keyer_top: Morse code keyer
// Turns one ASCII character into on/off keying segments with ITU timing.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o    char_code_i
//   out      output     out_valid_o/out_ready_i  key_on_o, length_units_o,
//                                                duration_ticks_o, last_segment_o
//   cfg      input      cfg_we_i                 cfg_wdata_i (unit time)
//
// Each element makes a mark and a gap segment (a full stop: 22 segments); the
// sequencer emits into the single segment register, so a stalled out_ready_i
// holds it back.
// A new character is taken once the last segment has been loaded.
// Reset (asynchronous, active low) clears the sequencer and sets unit time 100.
// ----------------------------------------------------------------------------
module morse_code_keyer_top import mck_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] char_code_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             key_on_o,
  output logic [LenW-1:0]  length_units_o,
  output logic [DurW-1:0]  duration_ticks_o,
  output logic             last_segment_o
);

  mck_cmd_t cmd;
  mck_sts_t sts;

  mck_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mck_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .char_code_i      (char_code_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .key_on_o         (key_on_o),
    .length_units_o   (length_units_o),
    .duration_ticks_o (duration_ticks_o),
    .last_segment_o   (last_segment_o)
  );

endmodule
